// ===== rtl/wsd_pkg.sv =====
// Shared constants for the windowed standard deviation stall detector.
package wsd_pkg;

  localparam int WINDOW_DEPTH_DEF = 256;

  localparam int STAMP_W = 32;
  localparam int VAL_W   = 24;
  localparam int DEV_W   = 23;
  localparam int TIME_W  = 16;
  localparam int LIMIT_W = 23;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEADY_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_LIMIT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFORT_LIMIT  = 2'd3;

  localparam logic [TIME_W-1:0]  WINDOW_TIME_RST  = 16'd5000;
  localparam logic [TIME_W-1:0]  STEADY_TIME_RST  = 16'd1000;
  localparam logic [LIMIT_W-1:0] POS_LIMIT_RST    = 23'd42;
  localparam logic [LIMIT_W-1:0] EFFORT_LIMIT_RST = 23'd41;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_GOAL   = 1'b1;

endpackage

// ===== rtl/wsd_ram.sv =====
// Generic single write port RAM with registered read.
module wsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/wsd_dev_unit.sv =====
// Iterative population deviation unit: n*Q - S*S, square root, divide by n.
module wsd_dev_unit #(
  parameter int CW = 9,
  parameter int SW = 32,
  parameter int QW = 55
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [CW-1:0]                 n,
  input  logic signed [SW-1:0]          s,
  input  logic [QW-1:0]                 q,
  output logic                          done,
  output logic [wsd_pkg::DEV_W-1:0]     dev
);

  localparam int DW  = QW + CW;
  localparam int RW  = (DW + 1) / 2;
  localparam int XW  = 2 * RW;
  localparam int RMW = RW + 3;
  localparam int CTW = $clog2(XW + 1);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MULA = 3'd1;
  localparam logic [2:0] P_MULB = 3'd2;
  localparam logic [2:0] P_SUB  = 3'd3;
  localparam logic [2:0] P_SQRT = 3'd4;
  localparam logic [2:0] P_DIV  = 3'd5;

  logic [2:0]     ph_r;
  logic [CTW-1:0] cnt_r;
  logic [CW-1:0]  n_r;
  logic [DW-1:0]  a_r, b_r, mcand_r;
  logic [SW-1:0]  mplier_r;
  logic [XW-1:0]  x_r;
  logic [RMW-1:0] rem_r;
  logic [RW-1:0]  root_r;
  logic           done_r;
  logic [wsd_pkg::DEV_W-1:0] dev_r;

  logic [SW-1:0]  mag;
  logic [DW-1:0]  acc_sum;
  logic [RMW-1:0] remp, trial;
  logic [CW:0]    dvp;

  assign mag     = s[SW-1] ? SW'(-s) : SW'(s);
  assign acc_sum = ((ph_r == P_MULA) ? a_r : b_r) + mcand_r;
  assign remp    = {rem_r[RW:0], x_r[XW-1:XW-2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign dvp     = {rem_r[CW-1:0], root_r[RW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= P_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ph_r) inside
        P_IDLE: begin
          if (start) begin
            n_r      <= n;
            a_r      <= '0;
            b_r      <= '0;
            mcand_r  <= DW'(q);
            mplier_r <= SW'(n);
            cnt_r    <= CTW'(CW);
            ph_r     <= P_MULA;
          end
        end
        P_MULA, P_MULB: begin
          if (mplier_r[0]) begin
            if (ph_r == P_MULA) a_r <= acc_sum;
            else                b_r <= acc_sum;
          end
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r - 1'b1;
          if (cnt_r == CTW'(1)) begin
            if (ph_r == P_MULA) begin
              mcand_r  <= DW'(mag);
              mplier_r <= mag;
              cnt_r    <= CTW'(SW);
              ph_r     <= P_MULB;
            end else begin
              ph_r <= P_SUB;
            end
          end
        end
        P_SUB: begin
          if (a_r <= b_r) begin
            dev_r  <= '0;
            done_r <= 1'b1;
            ph_r   <= P_IDLE;
          end else begin
            x_r    <= XW'(a_r - b_r);
            rem_r  <= '0;
            root_r <= '0;
            cnt_r  <= CTW'(RW);
            ph_r   <= P_SQRT;
          end
        end
        P_SQRT: begin
          if (remp >= trial) begin
            rem_r  <= remp - trial;
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            rem_r  <= remp;
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          x_r   <= x_r << 2;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CTW'(1)) begin
            rem_r <= '0;
            cnt_r <= CTW'(RW);
            ph_r  <= P_DIV;
          end
        end
        P_DIV: begin
          if (dvp >= {1'b0, n_r}) begin
            rem_r  <= RMW'(dvp - {1'b0, n_r});
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            rem_r  <= RMW'(dvp);
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CTW'(1)) begin
            dev_r  <= (dvp >= {1'b0, n_r}) ? {root_r[wsd_pkg::DEV_W-2:0], 1'b1}
                                           : {root_r[wsd_pkg::DEV_W-2:0], 1'b0};
            done_r <= 1'b1;
            ph_r   <= P_IDLE;
          end
        end
        default: ph_r <= P_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign dev  = dev_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (ph_r == P_IDLE)) else $error("deviation start while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("deviation done held");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (ph_r == P_IDLE)) else $error("deviation done while busy");

endmodule

// ===== rtl/windowed_stddev_stall_detector_unit.sv =====
// Top level of the windowed standard deviation stall detector.
// Sequencing: a goal item goes from transfer straight to the done state; a sample makes four
//   passes of the shared deviation unit, after dropping the oldest entry when the store is
//   full, then evicts stale entries; a pass with zero spread skips the square root and divide.
// Throughput: one item at a time; ready again the cycle after the result is registered.
// Reset: synchronous active low; clears control state, sums and configuration to defaults;
//   ring contents stay undefined and are never read before written.
module windowed_stddev_stall_detector_unit #(
  parameter int WINDOW_DEPTH = wsd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [wsd_pkg::STAMP_W-1:0]         in_stamp_ms,
  input  logic signed [wsd_pkg::VAL_W-1:0]    in_position,
  input  logic signed [wsd_pkg::VAL_W-1:0]    in_effort,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_stuck,
  output logic [wsd_pkg::DEV_W-1:0]           out_pos_deviation,
  output logic [wsd_pkg::DEV_W-1:0]           out_effort_deviation,
  input  logic                                cfg_we,
  input  logic [wsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsd_pkg::LIMIT_W-1:0]         cfg_data
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = wsd_pkg::VAL_W + AW;          // signed sum of values
  localparam int QW = 2 * wsd_pkg::VAL_W - 1 + AW;  // sum of squares
  localparam int VW = wsd_pkg::VAL_W;
  localparam int DVW = wsd_pkg::DEV_W;
  localparam int TW = wsd_pkg::STAMP_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DROP    = 4'd1;
  localparam logic [3:0] S_INS     = 4'd2;
  localparam logic [3:0] S_DEV     = 4'd3;
  localparam logic [3:0] S_DEVWAIT = 4'd4;
  localparam logic [3:0] S_DEVWR   = 4'd5;
  localparam logic [3:0] S_DADD    = 4'd6;
  localparam logic [3:0] S_CHECK   = 4'd7;
  localparam logic [3:0] S_EV_WAIT = 4'd8;
  localparam logic [3:0] S_EV_TEST = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  localparam logic [AW+1:0] DEPTH_X = (AW+2)'(WINDOW_DEPTH);

  // control
  logic [3:0]    state_r;
  logic [1:0]    k_r;
  logic          ret_evict_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] oldest_r, slot_r;
  logic          steady_r;
  logic [TW-1:0] steady_start_r;

  // item payload and results
  logic [TW-1:0]        stamp_r;
  logic signed [VW-1:0] pos_r, eff_r;
  logic [DVW-1:0]       pd_r, ed_r, p2_r, e2_r;
  logic                 stuck_r;

  logic                 out_valid_r, out_stuck_r;
  logic [DVW-1:0]       out_pd_r, out_ed_r;

  // configuration
  logic [wsd_pkg::TIME_W-1:0]  window_time_r, steady_time_r;
  logic [wsd_pkg::LIMIT_W-1:0] pos_limit_r, eff_limit_r;

  // running sums: pairs of (sum, square sum) for pos, effort, pos dev, effort dev
  logic signed [SW-1:0] s_r [4];
  logic [QW-1:0]        q_r [4];

  // ring read data at the oldest entry
  logic [TW-1:0]  stamp_rd;
  logic [VW-1:0]  pos_rd, eff_rd;
  logic [DVW-1:0] pd_rd, ed_rd;

  logic [AW-1:0]  slot_c, oldest_inc, waddr;
  logic [AW+1:0]  slot_sum;
  logic           core_we, dev_we;

  logic signed [VW-1:0]   pair_val;
  logic signed [2*VW-1:0] pair_sq;
  logic                   pair_sub, pair_en;
  logic signed [SW-1:0]   s_upd;
  logic [QW-1:0]          q_upd;

  logic           dev_done;
  logic [DVW-1:0] dev_res;

  logic [TW-1:0]  elapsed, steady_age;
  logic           over_window, cond;

  // next slot wraps at the window depth, which need not be a power of two
  assign slot_sum   = {2'b00, oldest_r} + (AW+2)'(count_r);
  assign slot_c     = (slot_sum >= DEPTH_X) ? AW'(slot_sum - DEPTH_X) : AW'(slot_sum);
  assign oldest_inc = (oldest_r == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_r + 1'b1;

  assign core_we = (state_r == S_INS) && (k_r == 2'd0);
  assign dev_we  = (state_r == S_DEVWR);
  assign waddr   = (state_r == S_INS) ? slot_c : slot_r;

  wsd_ram #(.WIDTH(TW), .DEPTH(WINDOW_DEPTH)) u_stamp_ram (
    .clk(clk), .we(core_we), .waddr(waddr), .wdata(stamp_r), .raddr(oldest_r),
    .rdata(stamp_rd));
  wsd_ram #(.WIDTH(VW), .DEPTH(WINDOW_DEPTH)) u_pos_ram (
    .clk(clk), .we(core_we), .waddr(waddr), .wdata(pos_r), .raddr(oldest_r),
    .rdata(pos_rd));
  wsd_ram #(.WIDTH(VW), .DEPTH(WINDOW_DEPTH)) u_eff_ram (
    .clk(clk), .we(core_we), .waddr(waddr), .wdata(eff_r), .raddr(oldest_r),
    .rdata(eff_rd));
  wsd_ram #(.WIDTH(DVW), .DEPTH(WINDOW_DEPTH)) u_pd_ram (
    .clk(clk), .we(dev_we), .waddr(waddr), .wdata(pd_r), .raddr(oldest_r),
    .rdata(pd_rd));
  wsd_ram #(.WIDTH(DVW), .DEPTH(WINDOW_DEPTH)) u_ed_ram (
    .clk(clk), .we(dev_we), .waddr(waddr), .wdata(ed_r), .raddr(oldest_r),
    .rdata(ed_rd));

  // Pair update: add the current item's value, or subtract the oldest entry's.
  assign pair_sub = (state_r == S_DROP);
  assign pair_en  = (state_r == S_DROP) || (state_r == S_INS) || (state_r == S_DADD);

  always_comb begin
    case (k_r)
      2'd0:    pair_val = pair_sub ? pos_rd : pos_r;
      2'd1:    pair_val = pair_sub ? eff_rd : eff_r;
      2'd2:    pair_val = pair_sub ? {1'b0, pd_rd} : {1'b0, pd_r};
      default: pair_val = pair_sub ? {1'b0, ed_rd} : {1'b0, ed_r};
    endcase
  end

  assign pair_sq = pair_val * pair_val;
  assign s_upd   = pair_sub ? s_r[k_r] - SW'(pair_val) : s_r[k_r] + SW'(pair_val);
  assign q_upd   = pair_sub ? q_r[k_r] - QW'(unsigned'(pair_sq))
                            : q_r[k_r] + QW'(unsigned'(pair_sq));

  wsd_dev_unit #(.CW(CW), .SW(SW), .QW(QW)) u_dev (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_DEV), .n(count_r),
    .s(s_r[k_r]), .q(q_r[k_r]), .done(dev_done), .dev(dev_res));

  // Window and steady tests; timestamps wrap modulo 2^32.
  assign elapsed     = stamp_r - stamp_rd;
  assign steady_age  = stamp_r - steady_start_r;
  assign over_window = elapsed > TW'(window_time_r);
  assign cond        = eff_r[VW-1] && over_window &&
                       (p2_r < pos_limit_r) && (e2_r < eff_limit_r);

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      k_r            <= '0;
      ret_evict_r    <= 1'b0;
      count_r        <= '0;
      oldest_r       <= '0;
      steady_r       <= 1'b0;
      steady_start_r <= '0;
      out_valid_r    <= 1'b0;
      window_time_r  <= wsd_pkg::WINDOW_TIME_RST;
      steady_time_r  <= wsd_pkg::STEADY_TIME_RST;
      pos_limit_r    <= wsd_pkg::POS_LIMIT_RST;
      eff_limit_r    <= wsd_pkg::EFFORT_LIMIT_RST;
      for (int i = 0; i < 4; i++) begin
        s_r[i] <= '0;
        q_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          wsd_pkg::CFG_WINDOW_TIME:  window_time_r <= cfg_data[wsd_pkg::TIME_W-1:0];
          wsd_pkg::CFG_STEADY_TIME:  steady_time_r <= cfg_data[wsd_pkg::TIME_W-1:0];
          wsd_pkg::CFG_POS_LIMIT:    pos_limit_r   <= cfg_data;
          wsd_pkg::CFG_EFFORT_LIMIT: eff_limit_r   <= cfg_data;
          default: ;
        endcase
      end

      // drop the output once the consumer takes the transfer
      if (out_valid && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (pair_en) begin
        s_r[k_r] <= s_upd;
        q_r[k_r] <= q_upd;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            stamp_r <= in_stamp_ms;
            pos_r   <= in_position;
            eff_r   <= in_effort;
            stuck_r <= 1'b0;
            k_r     <= '0;
            if (in_opcode == wsd_pkg::OP_GOAL) begin
              // goal: clear the store, the sums and the steady flag
              for (int i = 0; i < 4; i++) begin
                s_r[i] <= '0;
                q_r[i] <= '0;
              end
              count_r  <= '0;
              oldest_r <= '0;
              steady_r <= 1'b0;
              pd_r     <= '0;
              ed_r     <= '0;
              state_r  <= S_DONE;
            end else if (count_r == CW'(WINDOW_DEPTH)) begin
              // full store: drop the oldest entry before storing the new one
              ret_evict_r <= 1'b0;
              state_r     <= S_DROP;
            end else begin
              state_r <= S_INS;
            end
          end
        end
        S_DROP: begin
          k_r <= k_r + 1'b1;
          if (k_r == 2'd3) begin
            oldest_r <= oldest_inc;
            count_r  <= count_r - 1'b1;
            k_r      <= '0;
            state_r  <= ret_evict_r ? S_EV_WAIT : S_INS;
          end
        end
        S_INS: begin
          if (k_r == 2'd0) begin
            slot_r <= slot_c;
            k_r    <= 2'd1;
          end else begin
            count_r <= count_r + 1'b1;
            k_r     <= 2'd0;
            state_r <= S_DEV;
          end
        end
        S_DEV: begin
          state_r <= S_DEVWAIT;
        end
        S_DEVWAIT: begin
          if (dev_done) begin
            case (k_r)
              2'd0: begin
                pd_r    <= dev_res;
                k_r     <= 2'd1;
                state_r <= S_DEV;
              end
              2'd1: begin
                ed_r    <= dev_res;
                state_r <= S_DEVWR;
              end
              2'd2: begin
                p2_r    <= dev_res;
                k_r     <= 2'd3;
                state_r <= S_DEV;
              end
              default: begin
                e2_r    <= dev_res;
                state_r <= S_CHECK;
              end
            endcase
          end
        end
        S_DEVWR: begin
          k_r     <= 2'd2;
          state_r <= S_DADD;
        end
        S_DADD: begin
          if (k_r == 2'd3) begin
            k_r     <= 2'd2;
            state_r <= S_DEV;
          end else begin
            k_r <= 2'd3;
          end
        end
        S_CHECK: begin
          // a failing condition keeps the steady flag; stuck re-arms it
          if (cond) begin
            if (!steady_r) begin
              steady_start_r <= stamp_r;
              steady_r       <= 1'b1;
            end else if (steady_age >= TW'(steady_time_r)) begin
              stuck_r  <= 1'b1;
              steady_r <= 1'b0;
            end
          end
          state_r <= S_EV_TEST;
        end
        S_EV_WAIT: begin
          // wait state so the registered ring read reflects the new oldest entry
          state_r <= S_EV_TEST;
        end
        S_EV_TEST: begin
          if ((count_r > CW'(1)) && over_window) begin
            ret_evict_r <= 1'b1;
            k_r         <= '0;
            state_r     <= S_DROP;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_stuck_r <= stuck_r;
            out_pd_r    <= pd_r;
            out_ed_r    <= ed_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_stuck            = out_stuck_r;
  assign out_pos_deviation    = out_pd_r;
  assign out_effort_deviation = out_ed_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WINDOW_DEPTH)) else $error("entry count above depth");
  a_goal_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == wsd_pkg::OP_GOAL) |=>
      (count_r == '0 && !steady_r)) else $error("goal did not clear store");
  a_dev_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dev_done |-> (state_r == S_DEVWAIT)) else $error("deviation result unexpected");
  a_stuck_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && stuck_r) |-> !steady_r) else $error("stuck without re-arm");

endmodule
